// ===== rtl/set_all_key_value_table_core_macros.svh =====
// ----------------------------------------------------------------------------
// Set-all key/value table: assertion macros
// Shared assertion forms for the modules of the key/value table core.
// ----------------------------------------------------------------------------
`ifndef SET_ALL_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define SET_ALL_KEY_VALUE_TABLE_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define STAKV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property that must hold in the cycle after a condition, outside reset.
`define STAKV_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/stakv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-all key/value table package
// Sizes, request codes and the token and broadcast types of the cell chain.
// ----------------------------------------------------------------------------
package stakv_pkg;

    // Table geometry and field widths.
    localparam int ENTRIES     = 64;
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int COUNT_OUT_W = 7;

    // Value answered by a get that misses (all ones, that is -1).
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_GET    = 2'd1,
        REQ_SETALL = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // Held-key count.
    typedef logic [CNT_W-1:0] t_count;

    // A put or get travelling down the cell chain, one cell per cycle.
    typedef struct packed {
        logic              active;
        t_req              req;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic              done;
        logic              found;
        logic              fresh;
        logic              inserted;
    } t_tok;

    // Commands seen by every cell in the same cycle.
    typedef struct packed {
        logic set_all;
        logic clear;
    } t_bcast;

endpackage

// ===== rtl/stakv_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request per transfer.
// ----------------------------------------------------------------------------
interface stakv_req_if;
    import stakv_pkg::*;

    logic                    valid;
    logic                    ready;
    t_req                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] data_value;

    modport source (output valid, req_type, key, data_value, input ready);
    modport sink   (input valid, req_type, key, data_value, output ready);
endinterface

// ===== rtl/stakv_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface stakv_rsp_if;
    import stakv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]  entry_count;
    logic                    insert_dropped;

    modport source (output valid, found, read_value, entry_count, insert_dropped,
                     input ready);
    modport sink   (input valid, found, read_value, entry_count, insert_dropped,
                     output ready);
endinterface

// ===== rtl/set_all_key_value_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-all key/value table core
// Fully associative key/value table with put, get, set-all and clear.
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES cells, each holding one slot. A put or get
// is carried as a token that steps one cell per cycle down the row. Its result
// is taken from the token as it leaves the last cell, so the time that a put
// or get takes is set by the length of the cell row. The result waits in a
// result register and moves to the output register once that one is free.
// Set-all and clear reach every cell at once. Their result goes the same way,
// through the result register into the output register once that is free.
// One request is in the table at a time. The next is taken in the cycle after
// the previous result enters the output register, even while that result
// still waits for its transfer.
module set_all_key_value_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stakv_req_if.sink   i_req,
    stakv_rsp_if.source o_rsp
);
    import stakv_pkg::*;

    t_tok   w_chain [ENTRIES+1];
    t_bcast w_bc;

    // Request sequencing and result register.
    stakv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_tok   (w_chain[0]),
        .o_bc    (w_bc),
        .i_tok   (w_chain[ENTRIES])
    );

    // Row of slot cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        stakv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .i_bc    (w_bc),
            .o_tok   (w_chain[g+1])
        );
    end

endmodule

// ===== rtl/stakv_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table cell
// Holds one slot and passes the request token on to the next cell each cycle.
// ----------------------------------------------------------------------------
module stakv_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stakv_pkg::t_tok   i_tok,
    input  stakv_pkg::t_bcast i_bc,
    output stakv_pkg::t_tok   o_tok
);
    import stakv_pkg::*;

    logic             r_valid;
    logic             r_fresh;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    t_tok             r_tok;

    logic             n_valid;
    logic             n_fresh;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_value;
    t_tok             n_tok;

    logic             w_live;
    logic             w_match;
    logic             w_claim;

    // Slots fill from the front and are only emptied all at once, so the
    // first empty cell a put reaches proves that its key is absent.
    assign w_live  = i_tok.active & ~i_tok.done;
    assign w_match = w_live & r_valid & (r_key == i_tok.key);
    assign w_claim = w_live & ~r_valid & (i_tok.req == REQ_PUT);

    // Slot update and token hand-off.
    always_comb begin
        n_valid = r_valid;
        n_fresh = r_fresh;
        n_key   = r_key;
        n_value = r_value;
        n_tok   = i_tok;
        if (i_bc.clear) begin
            n_valid = 1'b0;
            n_fresh = 1'b0;
        end else if (i_bc.set_all) begin
            n_fresh = 1'b0;
        end else if (w_match) begin
            n_tok.done = 1'b1;
            if (i_tok.req == REQ_PUT) begin
                n_value = i_tok.value;
                n_fresh = 1'b1;
            end else begin
                n_tok.found = 1'b1;
                n_tok.fresh = r_fresh;
                n_tok.value = r_value;
            end
        end else if (w_claim) begin
            n_valid        = 1'b1;
            n_fresh        = 1'b1;
            n_key          = i_tok.key;
            n_value        = i_tok.value;
            n_tok.done     = 1'b1;
            n_tok.inserted = 1'b1;
        end
    end

    // Control flags and the token stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_fresh      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_fresh <= n_fresh;
            r_tok   <= n_tok;
        end
    end

    // Slot key and value.
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/stakv_ctrl.sv =====
`timescale 1ns / 1ps
`include "set_all_key_value_table_core_macros.svh"
// ----------------------------------------------------------------------------
// Table controller
// Takes requests, launches tokens into the cell chain, keeps the set-all value
// and the key count, and holds the result register.
// ----------------------------------------------------------------------------
module stakv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stakv_req_if.sink         i_req,
    stakv_rsp_if.source       o_rsp,
    output stakv_pkg::t_tok   o_tok,
    output stakv_pkg::t_bcast o_bc,
    input  stakv_pkg::t_tok   i_tok
);
    import stakv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
        t_count           count;
        logic             dropped;
    } t_res;

    t_state           r_state, n_state;
    t_tok             r_tok, n_tok;
    t_bcast           r_bc, n_bc;
    logic [VAL_W-1:0] r_bulk, n_bulk;
    t_count           r_count, n_count;
    t_res             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    logic             w_accept;
    logic             w_out_free;
    t_count           w_count_inc;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_out_free  = ~r_out_valid | o_rsp.ready;
    assign w_count_inc = r_count + t_count'(i_tok.inserted);

    // Request sequencing.
    always_comb begin
        n_state     = r_state;
        n_tok       = '0;
        n_bc        = '0;
        n_bulk      = r_bulk;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res = '{found: 1'b0, value: '0, count: r_count, dropped: 1'b0};
                    unique case (i_req.req_type) inside
                        REQ_PUT, REQ_GET: begin
                            n_tok.active = 1'b1;
                            n_tok.req    = i_req.req_type;
                            n_tok.key    = i_req.key;
                            n_tok.value  = i_req.data_value;
                            n_state      = ST_WALK;
                        end
                        REQ_SETALL: begin
                            n_bc.set_all = 1'b1;
                            n_bulk       = i_req.data_value;
                            n_state      = ST_HOLD;
                        end
                        REQ_CLEAR: begin
                            n_bc.clear  = 1'b1;
                            n_bulk      = '0;
                            n_count     = '0;
                            n_res.count = '0;
                            n_state     = ST_HOLD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                // The token leaves the last cell with its outcome.
                if (i_tok.active) begin
                    n_count       = w_count_inc;
                    n_res.found   = i_tok.found;
                    n_res.count   = w_count_inc;
                    n_res.dropped = (i_tok.req == REQ_PUT) & ~i_tok.done;
                    if (i_tok.req == REQ_GET) begin
                        if (!i_tok.found) begin
                            n_res.value = MISS_VALUE;
                        end else if (i_tok.fresh) begin
                            n_res.value = i_tok.value;
                        end else begin
                            n_res.value = r_bulk;
                        end
                    end else begin
                        n_res.value = '0;
                    end
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State, control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tok.active <= 1'b0;
            r_bc         <= '0;
            r_bulk       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok       <= n_tok;
            r_bc        <= n_bc;
            r_bulk      <= n_bulk;
            r_count     <= n_count;
            r_res       <= n_res;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    // Chain drive and response channel.
    assign o_tok                = r_tok;
    assign o_bc                 = r_bc;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.found          = r_out.found;
    assign o_rsp.read_value     = r_out.value;
    assign o_rsp.entry_count    = COUNT_OUT_W'(r_out.count);
    assign o_rsp.insert_dropped = r_out.dropped;

    // Checks on the sequencing.
    `STAKV_ASSERT(a_tok_in_walk, i_clk, i_rst_n, i_tok.active |-> r_state == ST_WALK, "token returned outside a walk")
    `STAKV_ASSERT_NEXT(a_tok_launch, i_clk, i_rst_n, w_accept && (i_req.req_type == REQ_PUT || i_req.req_type == REQ_GET), r_tok.active, "put or get did not launch a token")
    `STAKV_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(ENTRIES), "key count above table size")
    `STAKV_ASSERT(a_drop_full, i_clk, i_rst_n, (r_state == ST_HOLD && r_res.dropped) |-> r_count == CNT_W'(ENTRIES), "put dropped while table not full")

endmodule
